// File: rtl/core/lpfb_pkg.sv
// ----------------------------------------------------------------------------
// LCD page frame buffer package
// Shared constants, codes, types and the init command table of the block.
// ----------------------------------------------------------------------------
package lpfb_pkg;

  // Geometry of the frame store.
  localparam int MAX_COLUMNS = 132;
  localparam int MAX_PAGES   = 8;
  localparam int STORE_DEPTH = MAX_COLUMNS * MAX_PAGES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int COL_W      = 8;
  localparam int PAGES_W    = 4;
  localparam int PAGE_W     = 3;
  localparam int Y_W        = 6;
  localparam int BYTE_W     = 8;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Init command run.
  localparam int INIT_LEN   = 14;
  localparam int INIT_CNT_W = $clog2(INIT_LEN);
  localparam logic [INIT_CNT_W-1:0] INIT_LAST = INIT_CNT_W'(INIT_LEN - 1);

  // Display command codes.
  localparam logic [BYTE_W-1:0] CMD_PAGE  = 8'b1011_0000;
  localparam logic [BYTE_W-1:0] CMD_POWER = 8'b0010_1000;
  localparam logic [BYTE_W-1:0] CMD_ON    = 8'b1010_1111;
  localparam logic [BYTE_W-1:0] CMD_OFF   = 8'b1010_1110;

  typedef enum logic [MODE_W-1:0] {
    MODE_DRAW    = 3'd0,
    MODE_ERASE   = 3'd1,
    MODE_TOGGLE  = 3'd2,
    MODE_REFRESH = 3'd3,
    MODE_INIT    = 3'd4,
    MODE_ON      = 3'd5,
    MODE_OFF     = 3'd6,
    MODE_POWER   = 3'd7
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 1'b0,
    CFG_PAGES   = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_WAIT  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic load_item;
    logic mem_rd;
    logic pix_wr;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic in_mem_op;
    logic item_pixel;
    logic init_more;
    logic out_free;
  } dp_status_t;

  function automatic logic [BYTE_W-1:0] init_byte(input logic [INIT_CNT_W-1:0] i);
    logic [BYTE_W-1:0] b;
    case (i)
      4'd0:    b = 8'b0100_0000;
      4'd1:    b = 8'b1010_0001;
      4'd2:    b = 8'b1100_0000;
      4'd3:    b = 8'b1010_0110;
      4'd4:    b = 8'b1010_0010;
      4'd5:    b = 8'b0010_1111;
      4'd6:    b = 8'b1111_1000;
      4'd7:    b = 8'h00;
      4'd8:    b = 8'h23;
      4'd9:    b = 8'h81;
      4'd10:   b = 8'h1F;
      4'd11:   b = 8'hAC;
      4'd12:   b = 8'h00;
      4'd13:   b = CMD_ON;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/lpfb_if.sv
// ----------------------------------------------------------------------------
// LCD page frame buffer channel interfaces
// Item, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lpfb_in_if;
  logic                         valid;
  logic                         ready;
  logic [lpfb_pkg::MODE_W-1:0]  mode;
  logic [lpfb_pkg::COL_W-1:0]   pixel_x;
  logic [lpfb_pkg::Y_W-1:0]     pixel_y;
  logic                         booster_on;
  logic                         regulator_on;
  logic                         follower_on;

  modport source (output valid, mode, pixel_x, pixel_y, booster_on, regulator_on,
                  follower_on, input ready);
  modport sink (input valid, mode, pixel_x, pixel_y, booster_on, regulator_on,
                follower_on, output ready);
endinterface

interface lpfb_out_if;
  logic                         valid;
  logic                         ready;
  logic [lpfb_pkg::BYTE_W-1:0]  out_byte;
  logic                         is_data;
  logic                         last;

  modport source (output valid, out_byte, is_data, last, input ready);
  modport sink (input valid, out_byte, is_data, last, output ready);
endinterface

interface lpfb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lpfb_pkg::CFG_IDX_W-1:0]   index;
  logic [lpfb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/lpfb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/lpfb_ctrl.sv
// ----------------------------------------------------------------------------
// LCD page frame buffer controller
// Sequences the store clear, pixel read-modify-write and result emission.
// ----------------------------------------------------------------------------
module lpfb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lpfb_pkg::dp_status_t st,
  output lpfb_pkg::ctrl_cmd_t  cmd
);
  import lpfb_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = st.in_mem_op ? S_READ : S_EMIT;
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        // Pixel items finish here with the write back of the modified word.
        if (st.item_pixel) begin
          cmd.pix_wr = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          if (!st.init_more) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/lpfb_datapath.sv
// ----------------------------------------------------------------------------
// LCD page frame buffer datapath
// Frame store, area registers, refresh position, command bytes and the
// output register.
// ----------------------------------------------------------------------------
module lpfb_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lpfb_pkg::ctrl_cmd_t                cmd,
  output lpfb_pkg::dp_status_t               st,
  input  logic [lpfb_pkg::MODE_W-1:0]        in_mode,
  input  logic [lpfb_pkg::COL_W-1:0]         in_pixel_x,
  input  logic [lpfb_pkg::Y_W-1:0]           in_pixel_y,
  input  logic                               in_booster_on,
  input  logic                               in_regulator_on,
  input  logic                               in_follower_on,
  input  logic                               cfg_we,
  input  logic [lpfb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpfb_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lpfb_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_is_data,
  output logic                               out_last
);
  import lpfb_pkg::*;

  // Area registers.
  logic [COL_W-1:0]   cols_r;
  logic [PAGES_W-1:0] pages_r;
  logic [COL_W-1:0]   cols_eff;
  logic [PAGES_W-1:0] pages_eff;

  // Item registers.
  mode_t            mode_r;
  logic [COL_W-1:0] x_r;
  logic [Y_W-1:0]   y_r;
  logic [2:0]       pwr_r;

  // Counters and refresh position.
  logic [ADDR_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [INIT_CNT_W-1:0] init_cnt_r, init_cnt_nxt;
  logic [PAGE_W-1:0]     rf_page_r, rf_page_nxt;
  logic [COL_W-1:0]      rf_col_r, rf_col_nxt;
  logic                  rf_data_r, rf_data_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_is_data_r, out_is_data_nxt;
  logic              out_last_r, out_last_nxt;

  // Combinational terms.
  logic [PAGE_W-1:0]  pix_page;
  logic               pix_ok;
  logic [ADDR_W-1:0]  pix_addr;
  logic               page_bad, col_bad;
  logic [PAGE_W-1:0]  rf_page_n;
  logic [COL_W-1:0]   rf_col_0, rf_col_n, rf_col_inc;
  logic               rf_data_0, rf_data_n;
  logic [PAGES_W-1:0] rf_page_inc;
  logic               col_wrap, page_wrap;
  logic [ADDR_W-1:0]  rf_addr;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               ram_we;
  logic [BYTE_W-1:0]  ram_wdata, ram_rdata, bit_mask, mod_byte;
  mode_t              in_mode_c;

  assign in_mode_c = mode_t'(in_mode);

  // Register values outside their range are saturated where they are used.
  always_comb begin
    if (cols_r == '0) begin
      cols_eff = COL_W'(1);
    end else if (cols_r > COL_W'(MAX_COLUMNS)) begin
      cols_eff = COL_W'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_r;
    end
    if (pages_r == '0) begin
      pages_eff = PAGES_W'(1);
    end else if (pages_r > PAGES_W'(MAX_PAGES)) begin
      pages_eff = PAGES_W'(MAX_PAGES);
    end else begin
      pages_eff = pages_r;
    end
  end

  // Pixel addressing.
  assign pix_page = y_r[Y_W-1:3];
  assign pix_ok   = (x_r < cols_eff) && ({1'b0, pix_page} < pages_eff);
  assign pix_addr = ADDR_W'(cols_eff) * ADDR_W'(pix_page) + ADDR_W'(x_r);
  assign bit_mask = BYTE_W'(1) << y_r[2:0];

  always_comb begin
    case (mode_r)
      MODE_DRAW:  mod_byte = ram_rdata | bit_mask;
      MODE_ERASE: mod_byte = ram_rdata & ~bit_mask;
      default:    mod_byte = ram_rdata ^ bit_mask;
    endcase
  end

  // Refresh position, pulled back into the area when the area has shrunk.
  always_comb begin
    page_bad    = {1'b0, rf_page_r} >= pages_eff;
    rf_page_n   = page_bad ? '0 : rf_page_r;
    rf_col_0    = page_bad ? '0 : rf_col_r;
    rf_data_0   = page_bad ? 1'b0 : rf_data_r;
    col_bad     = rf_data_0 && (rf_col_0 >= cols_eff);
    rf_data_n   = rf_data_0 && !col_bad;
    rf_col_n    = col_bad ? '0 : rf_col_0;
    rf_col_inc  = rf_col_n + COL_W'(1);
    col_wrap    = rf_col_inc >= cols_eff;
    rf_page_inc = {1'b0, rf_page_n} + PAGES_W'(1);
    page_wrap   = rf_page_inc >= pages_eff;
    rf_addr     = ADDR_W'(cols_eff) * ADDR_W'(rf_page_n) + ADDR_W'(rf_col_n);
  end

  // Frame store ports; a pixel outside the area never writes the store.
  always_comb begin
    if (mode_r == MODE_REFRESH) begin
      rd_addr = rf_addr;
    end else begin
      rd_addr = pix_ok ? pix_addr : '0;
    end
    ram_we    = cmd.clear_wr || (cmd.pix_wr && pix_ok);
    wr_addr   = cmd.clear_wr ? clr_cnt_r : pix_addr;
    ram_wdata = cmd.clear_wr ? '0 : mod_byte;
  end

  lpfb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .re    (cmd.mem_rd),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Result word for the current item.
  always_comb begin
    out_byte_nxt    = out_byte_r;
    out_is_data_nxt = out_is_data_r;
    out_last_nxt    = out_last_r;
    if (cmd.load_out) begin
      case (mode_r)
        MODE_REFRESH: begin
          if (!rf_data_n) begin
            out_byte_nxt    = CMD_PAGE | BYTE_W'(rf_page_n);
            out_is_data_nxt = 1'b0;
            out_last_nxt    = 1'b0;
          end else begin
            out_byte_nxt    = ram_rdata;
            out_is_data_nxt = 1'b1;
            out_last_nxt    = col_wrap && page_wrap;
          end
        end
        MODE_INIT: begin
          out_byte_nxt    = init_byte(init_cnt_r);
          out_is_data_nxt = 1'b0;
          out_last_nxt    = init_cnt_r == INIT_LAST;
        end
        MODE_ON: begin
          out_byte_nxt    = CMD_ON;
          out_is_data_nxt = 1'b0;
          out_last_nxt    = 1'b1;
        end
        MODE_OFF: begin
          out_byte_nxt    = CMD_OFF;
          out_is_data_nxt = 1'b0;
          out_last_nxt    = 1'b1;
        end
        MODE_POWER: begin
          out_byte_nxt    = CMD_POWER | BYTE_W'(pwr_r);
          out_is_data_nxt = 1'b0;
          out_last_nxt    = 1'b1;
        end
        default: begin
          out_byte_nxt    = '0;
          out_is_data_nxt = 1'b0;
          out_last_nxt    = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Refresh position advances once per refresh word emitted.
  always_comb begin
    rf_page_nxt = rf_page_r;
    rf_col_nxt  = rf_col_r;
    rf_data_nxt = rf_data_r;
    if (cmd.load_out && (mode_r == MODE_REFRESH)) begin
      if (!rf_data_n) begin
        rf_page_nxt = rf_page_n;
        rf_col_nxt  = '0;
        rf_data_nxt = 1'b1;
      end else if (col_wrap) begin
        rf_col_nxt  = '0;
        rf_data_nxt = 1'b0;
        rf_page_nxt = page_wrap ? '0 : rf_page_inc[PAGE_W-1:0];
      end else begin
        rf_page_nxt = rf_page_n;
        rf_col_nxt  = rf_col_inc;
      end
    end
  end

  always_comb begin
    clr_cnt_nxt = cmd.clear_wr ? clr_cnt_r + ADDR_W'(1) : clr_cnt_r;
    if (cmd.load_item) begin
      init_cnt_nxt = '0;
    end else if (cmd.load_out && (mode_r == MODE_INIT)) begin
      init_cnt_nxt = init_cnt_r + INIT_CNT_W'(1);
    end else begin
      init_cnt_nxt = init_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= COL_W'(132);
      pages_r     <= PAGES_W'(4);
      clr_cnt_r   <= '0;
      init_cnt_r  <= '0;
      rf_page_r   <= '0;
      rf_col_r    <= '0;
      rf_data_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_COLUMNS: cols_r  <= cfg_data[COL_W-1:0];
          CFG_PAGES:   pages_r <= cfg_data[PAGES_W-1:0];
          default:     cols_r  <= cols_r;
        endcase
      end
      clr_cnt_r   <= clr_cnt_nxt;
      init_cnt_r  <= init_cnt_nxt;
      rf_page_r   <= rf_page_nxt;
      rf_col_r    <= rf_col_nxt;
      rf_data_r   <= rf_data_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r <= in_mode_c;
      x_r    <= in_pixel_x;
      y_r    <= in_pixel_y;
      pwr_r  <= {in_booster_on, in_regulator_on, in_follower_on};
    end
    out_byte_r    <= out_byte_nxt;
    out_is_data_r <= out_is_data_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_comb begin
    st.clear_done = clr_cnt_r == ADDR_W'(STORE_DEPTH - 1);
    st.in_mem_op  = (in_mode_c == MODE_DRAW) || (in_mode_c == MODE_ERASE) ||
                    (in_mode_c == MODE_TOGGLE) || (in_mode_c == MODE_REFRESH);
    st.item_pixel = mode_r != MODE_REFRESH;
    st.init_more  = (mode_r == MODE_INIT) && (init_cnt_r != INIT_LAST);
    st.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_data = out_is_data_r;
  assign out_last    = out_last_r;

endmodule

// File: rtl/core/lcd_page_framebuffer_controller_unit.sv
// ----------------------------------------------------------------------------
// LCD page frame buffer controller unit
// Page-organised monochrome frame store and display byte stream generator.
// ----------------------------------------------------------------------------
// Usage. Items arrive on in_ch: set, clear or invert one pixel, step the
// refresh by one byte, or request a fixed command run (init, switch on,
// switch off, power control). Result words leave on out_ch as a byte, the A0
// level (is_data) and a last flag that closes a transfer. Area registers
// (columns, pages in use) are written on cfg_ch, which is always ready; write
// them only while the block is idle.
// Timing. One item is handled at a time. A pixel item is accepted, its store
// word read, then the modified word written back. A refresh item is accepted,
// its store word read and waited for, then its result word loaded; a single
// command skips the store read. The block is ready again in the cycle after
// the word is loaded. Init gives 14 words, one per cycle while the receiver
// takes them. Reset. After rst_n the store is cleared one word per cycle, all
// 1056 words, during which in_ch.ready stays low. When the receiver stalls,
// the output register holds its word and a new item is still accepted; its
// result waits until the register frees.
// ----------------------------------------------------------------------------
module lcd_page_framebuffer_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  lpfb_in_if.sink     in_ch,
  lpfb_out_if.source  out_ch,
  lpfb_cfg_if.sink    cfg_ch
);
  import lpfb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  assign cfg_ch.ready = 1'b1;

  lpfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  lpfb_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_mode         (in_ch.mode),
    .in_pixel_x      (in_ch.pixel_x),
    .in_pixel_y      (in_ch.pixel_y),
    .in_booster_on   (in_ch.booster_on),
    .in_regulator_on (in_ch.regulator_on),
    .in_follower_on  (in_ch.follower_on),
    .cfg_we          (cfg_ch.valid && cfg_ch.ready),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_byte        (out_ch.out_byte),
    .out_is_data     (out_ch.is_data),
    .out_last        (out_ch.last)
  );

endmodule

// File: rtl/core/lpfb_checker.sv
// ----------------------------------------------------------------------------
// LCD page frame buffer port checker
// Port-level properties of the block, bound to the top level.
// ----------------------------------------------------------------------------
module lpfb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lpfb_pkg::BYTE_W-1:0]   out_byte,
  input logic                          is_data,
  input logic                          last
);
  import lpfb_pkg::*;

  // The store clear keeps items out in the first cycle after reset.
  a_clear_blocks_items: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("item channel ready straight after reset");

  a_no_word_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result word present straight after reset");

  // A stalled word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_data)
      && $stable(last))
    else $error("stalled result word changed");

  // A page command never closes a transfer.
  a_page_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_data && (out_byte[7:3] == CMD_PAGE[7:3]) |-> !last)
    else $error("page command flagged as last");

endmodule

bind lcd_page_framebuffer_controller_unit lpfb_checker u_lpfb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .is_data   (out_ch.is_data),
  .last      (out_ch.last)
);
